### design/hte_pkg.sv
// ----------------------------------------------------------------------------
// hte_pkg: shared types and constants of the Hall tachometer with EMA filter
// Controller states, command and status groups, register indexes and the
// fixed-point constants of the rpm arithmetic.
// ----------------------------------------------------------------------------
package hte_pkg;

	// Configuration register indexes.
	localparam logic [7:0] CFG_HIGH_THR = 8'd0;
	localparam logic [7:0] CFG_LOW_THR  = 8'd1;
	localparam logic [7:0] CFG_PPR      = 8'd2;
	localparam logic [7:0] CFG_ALPHA    = 8'd3;

	// Register reset values.
	localparam logic [9:0]  HIGH_THR_RST = 10'd600;
	localparam logic [9:0]  LOW_THR_RST  = 10'd500;
	localparam logic [7:0]  PPR_RST      = 8'd1;
	localparam logic [16:0] ALPHA_RST    = 17'd32768;

	// Input op codes.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	// 60000 ms per minute times 256 for the 16.8 result.
	localparam logic [23:0] NUM_SCALE     = 24'd15360000;
	localparam int          DIV_BITS      = 40;
	localparam logic [16:0] ALPHA_ONE     = 17'd65536;
	localparam logic [41:0] ROUND_HALF    = 42'd32768;
	localparam logic [23:0] RPM_MAX       = 24'hFFFFFF;
	localparam logic [15:0] SLOW_RPM      = 16'd300;
	localparam logic [8:0]  SLOW_INTERVAL = 9'd300;
	localparam logic [8:0]  MIN_INTERVAL  = 9'd1;
	// Integer rpm at which the interval reaches its 1 ms floor.
	localparam logic [15:0] FAST_RPM      = 16'd2094;
	// ceil(2^18 / 6): x / 6 == (x * DIV6_RECIP) >> 18 for x below 2^17.
	localparam logic [15:0] DIV6_RECIP    = 16'd43691;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SAMPLE,
		ST_CHECK,
		ST_MUL,
		ST_DIVIDE,
		ST_EMA_A,
		ST_EMA_B,
		ST_INTV_A,
		ST_INTV_B,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_in;
		logic sample;
		logic check;
		logic mul;
		logic div_step;
		logic ema_a;
		logic ema_b;
		logic intv_a;
		logic intv_b;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic late;
		logic div_done;
	} sts_t;

endpackage

### design/hte_ctrl.sv
// ----------------------------------------------------------------------------
// hte_ctrl: sequencing state machine of the tachometer
// Steps one item through the datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
module hte_ctrl import hte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.op == OP_SAMPLE) state_nxt = ST_SAMPLE;
				else if (sts.late) state_nxt = ST_DONE;
				else state_nxt = ST_MUL;
			end
			ST_SAMPLE: state_nxt = ST_DONE;
			ST_MUL:    state_nxt = ST_DIVIDE;
			ST_DIVIDE: begin
				if (sts.div_done) state_nxt = ST_EMA_A;
			end
			ST_EMA_A:  state_nxt = ST_EMA_B;
			ST_EMA_B:  state_nxt = ST_INTV_A;
			ST_INTV_A: state_nxt = ST_INTV_B;
			ST_INTV_B: state_nxt = ST_DONE;
			ST_DONE: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.load_in  = in_valid;
			ST_CHECK:  cmd.check    = 1'b1;
			ST_SAMPLE: cmd.sample   = 1'b1;
			ST_MUL:    cmd.mul      = 1'b1;
			ST_DIVIDE: cmd.div_step = !sts.div_done;
			ST_EMA_A:  cmd.ema_a    = 1'b1;
			ST_EMA_B:  cmd.ema_b    = 1'b1;
			ST_INTV_A: cmd.intv_a   = 1'b1;
			ST_INTV_B: cmd.intv_b   = 1'b1;
			ST_DONE:   cmd.load_out = out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

### design/hte_dp.sv
// ----------------------------------------------------------------------------
// hte_dp: datapath of the tachometer
// Configuration registers, hysteresis detector, pulse counter, the
// restoring divider for raw rpm, the EMA multiply-accumulate and the
// interval selection, plus the result register.
// ----------------------------------------------------------------------------
module hte_dp import hte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [7:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        in_op,
	input  logic [9:0]  in_hall,
	input  logic [31:0] in_now,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic [23:0] out_rpm,
	output logic        out_measured,
	output logic [8:0]  out_interval,
	output logic        out_magnet,
	output logic [15:0] out_pulses
);

	logic [9:0]  high_thr_q;
	logic [9:0]  low_thr_q;
	logic [7:0]  ppr_q;
	logic [16:0] alpha_q;

	logic        armed_q;
	logic [15:0] pulse_q;
	logic [31:0] last_q;
	logic [23:0] filt_q;
	logic [8:0]  intv_q;
	logic        meas_q;

	logic        op_q;
	logic [9:0]  hall_q;
	logic [31:0] now_q;

	logic [31:0] elapsed_q;
	logic [39:0] den_q;
	logic [39:0] rem_q;
	logic [39:0] quo_q;
	logic [5:0]  cnt_q;
	logic [41:0] acc_q;
	logic        slow_q;
	logic        fast_q;
	logic [10:0] diff_q;

	logic [31:0] elapsed;
	logic [7:0]  ppr_eff;
	logic [16:0] alpha_eff;
	logic [40:0] rem_sh;
	logic [41:0] trial;
	logic        borrow;
	logic [23:0] raw;
	logic [15:0] whole;
	logic [15:0] whole_off;
	logic [26:0] drop_prod;
	logic [8:0]  drop;

	assign elapsed   = now_q - last_q;
	assign ppr_eff   = (ppr_q == 8'd0) ? 8'd1 : ppr_q;
	assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;

	assign sts.op       = op_q;
	assign sts.late     = (elapsed < {23'd0, intv_q});
	assign sts.div_done = (cnt_q == 6'(DIV_BITS));

	// One restoring division step: the numerator shifts out of quo_q into
	// the partial remainder while quotient bits shift in from the right.
	assign rem_sh = {rem_q, quo_q[39]};
	assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
	assign borrow = trial[41];

	// A zero denominator yields an all-ones quotient, which saturates.
	assign raw = (pulse_q == 16'd0) ? 24'd0
	           : (quo_q[39:24] != 16'd0) ? RPM_MAX : quo_q[23:0];

	assign whole     = acc_q[39:24];
	assign whole_off = whole - SLOW_RPM;
	assign drop_prod = 27'(diff_q) * 27'(DIV6_RECIP);
	assign drop      = drop_prod[26:18];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q <= HIGH_THR_RST;
			low_thr_q  <= LOW_THR_RST;
			ppr_q      <= PPR_RST;
			alpha_q    <= ALPHA_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HIGH_THR: high_thr_q <= cfg_data[9:0];
				CFG_LOW_THR:  low_thr_q  <= cfg_data[9:0];
				CFG_PPR:      ppr_q      <= cfg_data[7:0];
				CFG_ALPHA:    alpha_q    <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			pulse_q <= 16'd0;
			last_q  <= 32'd0;
			filt_q  <= 24'd0;
			intv_q  <= 9'd0;
			meas_q  <= 1'b0;
			cnt_q   <= 6'd0;
		end else begin
			if (cmd.load_in) meas_q <= 1'b0;
			if (cmd.sample) begin
				if (hall_q > high_thr_q && !armed_q) begin
					armed_q <= 1'b1;
					if (pulse_q != 16'hFFFF) pulse_q <= pulse_q + 16'd1;
				end else if (hall_q < low_thr_q && armed_q) begin
					armed_q <= 1'b0;
				end
			end
			if (cmd.mul) cnt_q <= 6'd0;
			else if (cmd.div_step) cnt_q <= cnt_q + 6'd1;
			if (cmd.intv_a) begin
				filt_q  <= acc_q[39:16];
				pulse_q <= 16'd0;
				last_q  <= now_q;
				meas_q  <= 1'b1;
			end
			if (cmd.intv_b) begin
				if (slow_q) intv_q <= SLOW_INTERVAL;
				else if (fast_q) intv_q <= MIN_INTERVAL;
				else intv_q <= SLOW_INTERVAL - drop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= in_op;
			hall_q <= in_hall;
			now_q  <= in_now;
		end
		if (cmd.check) elapsed_q <= elapsed;
		if (cmd.mul) begin
			quo_q <= 40'(pulse_q) * 40'(NUM_SCALE);
			den_q <= 40'(ppr_eff) * 40'(elapsed_q);
			rem_q <= 40'd0;
		end else if (cmd.div_step) begin
			rem_q <= borrow ? rem_sh[39:0] : trial[39:0];
			quo_q <= {quo_q[38:0], !borrow};
		end
		if (cmd.ema_a) acc_q <= 42'(alpha_eff) * 42'(raw);
		else if (cmd.ema_b)
			acc_q <= acc_q + 42'(ALPHA_ONE - alpha_eff) * 42'(filt_q) + ROUND_HALF;
		if (cmd.intv_a) begin
			slow_q <= (whole < SLOW_RPM);
			fast_q <= (whole >= FAST_RPM);
			diff_q <= whole_off[10:0];
		end
		if (cmd.load_out) begin
			out_rpm      <= filt_q;
			out_measured <= meas_q;
			out_interval <= intv_q;
			out_magnet   <= armed_q;
			out_pulses   <= pulse_q;
		end
	end

endmodule

### design/hall_tachometer_ema_unit.sv
// ----------------------------------------------------------------------------
// hall_tachometer_ema_unit: Hall tachometer with hysteresis and EMA filter
// Flow: one item at a time; the next item is accepted only after the
// result of the last has loaded. An update with a measurement also runs
// the 40-step restoring divider for the raw rpm quotient.
// Reset: arst_n clears detector, count, time, filter and interval at once.
// ----------------------------------------------------------------------------
module hall_tachometer_ema_unit import hte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [16:0] cfg_data,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // hall_sample[9:0], now_ms[41:10], zero pad
	input  logic        s_tuser,  // op
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// rpm_value[23:0], interval_ms[32:24], magnet_present[33], pulses[49:34], pad
	output logic [55:0] m_tdata,
	output logic        m_tuser   // measured
);

	cmd_t        cmd;
	sts_t        sts;
	logic [23:0] rpm_value;
	logic        measured;
	logic [8:0]  interval_ms;
	logic        magnet_present;
	logic [15:0] pulses;

	// Registers are to be written only while the block is idle; the block
	// itself does not enforce this, and writes are always taken.
	assign cfg_ready = 1'b1;

	// The controller walks each transaction through the datapath: a sample
	// updates the detector in one step, an update first checks elapsed time
	// against the interval and, when due, runs product, division, the two
	// EMA accumulate steps and the interval choice before the result loads.
	hte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hte_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_op        (s_tuser),
		.in_hall      (s_tdata[9:0]),
		.in_now       (s_tdata[41:10]),
		.cmd          (cmd),
		.sts          (sts),
		.out_rpm      (rpm_value),
		.out_measured (measured),
		.out_interval (interval_ms),
		.out_magnet   (magnet_present),
		.out_pulses   (pulses)
	);

	// The result register holds a finished transaction while the next one is
	// already being accepted and worked on.
	assign m_tdata = {6'd0, pulses, magnet_present, interval_ms, rpm_value};
	assign m_tuser = measured;

	// An accepted item is worked on alone: no second acceptance right after.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in progress");

	// A measurement always leaves a cleared count and a legal interval.
	a_meas_clears: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> pulses == 16'd0)
		else $error("pulse count not cleared by a measurement");

	a_meas_interval: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> interval_ms != 9'd0 && interval_ms <= SLOW_INTERVAL)
		else $error("measurement interval out of range");

	// The result register only loads once any held result has been taken.
	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !m_tvalid || m_tready)
		else $error("result overwritten while still waiting");

endmodule

### sim/tb_hall_tachometer_ema_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hall_tachometer_ema_unit: self-checking bench of the Hall tachometer
// A directed table runs first. It covers threshold edges, the zero-elapsed
// measurement, time wrap, a zero pulses-per-rev value and an alpha above one.
// Random phases follow, built from magnet passes and timed update requests
// under changing register settings. A calm run of back-to-back magnet passes
// and a final measurement closes the test. Every result is checked against a
// predictor or, in some directed rows, a hand-written expectation.
// ----------------------------------------------------------------------------
module tb_hall_tachometer_ema_unit;
	import hte_pkg::*;

	localparam int CYCLE_LIMIT   = 4000000;
	localparam int PHASE_COUNT   = 8;
	localparam int PHASE_ITEMS   = 190;
	localparam int HOLD_OFF_LEN  = 400;
	localparam int PRINT_CAP     = 40;
	// Magnet passes sent back to back in the calm part.
	localparam int CALM_PASSES   = 24;

	// One result transaction, unpacked from m_tdata and m_tuser.
	typedef struct packed {
		logic [23:0] rpm;
		logic        measured;
		logic [8:0]  intv;
		logic        magnet;
		logic [15:0] pulses;
	} tach_result_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	// A row of the directed table: either an input item or a register write.
	// Rows with typed set carry a hand-written expectation.
	typedef struct packed {
		row_kind_t    kind;
		logic         op;
		logic [9:0]   level;
		logic [31:0]  now;
		logic [7:0]   idx;
		logic [16:0]  val;
		logic         typed;
		tach_result_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [16:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;  // hall_sample[9:0], now_ms[41:10], zero pad
	logic        s_tuser;  // op
	logic        m_tvalid;
	logic        m_tready;
	// rpm_value[23:0], interval_ms[32:24], magnet_present[33], pulses[49:34], pad
	logic [55:0] m_tdata;
	logic        m_tuser;  // measured

	// Predictor copy of the registers.
	logic [9:0]  hi_thr;
	logic [9:0]  lo_thr;
	logic [7:0]  ppr_reg;
	logic [16:0] alpha_reg;

	// Predictor copy of the block state.
	logic        armed;
	logic [15:0] pulse_cnt;
	logic [31:0] last_ms;
	logic [23:0] rpm_filt;
	logic [8:0]  intv_ms;

	tach_result_t result_q[$];
	dir_row_t     dir_rows[$];

	int          err_count = 0;
	int          results_seen = 0;
	int          items_sent;
	int          cycle_cnt = 0;
	bit          calm;
	bit          held = 1'b0;
	logic [31:0] clock_ms;
	int          pulse_ms;

	hall_tachometer_ema_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_hall_tachometer_ema_unit: errors");
			$finish;
		end
	end

	// Prints one line per mismatch and counts it. Printing stops after 40
	// lines so that a badly broken block does not flood the log.
	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		if (err_count < PRINT_CAP)
			$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// Advances the predicted tachometer by one item and returns the result
	// the block should give for it.
	function automatic tach_result_t tach_step(input logic op, input logic [9:0] level,
			input logic [31:0] now);
		logic [31:0]     elapsed;
		longint unsigned num;
		longint unsigned den;
		longint unsigned raw;
		longint unsigned a;
		longint unsigned acc;
		logic [15:0]     whole;
		logic [15:0]     drop;
		logic            meas;
		tach_result_t    r;
		meas = 1'b0;
		if (op == OP_SAMPLE) begin
			// Hysteresis: arm above the high level, rearm below the low level.
			if (level > hi_thr && !armed) begin
				armed = 1'b1;
				if (pulse_cnt != 16'hFFFF)
					pulse_cnt = pulse_cnt + 16'd1;
			end else if (level < lo_thr && armed) begin
				armed = 1'b0;
			end
		end else begin
			elapsed = now - last_ms;
			if (elapsed >= {23'd0, intv_ms}) begin
				meas = 1'b1;
				if (elapsed == 32'd0) begin
					raw = (pulse_cnt != 16'd0) ? 64'hFFFFFF : 64'd0;
				end else begin
					num = 64'(pulse_cnt);
					num = num * 64'd15360000;
					den = (ppr_reg == 8'd0) ? 64'd1 : 64'(ppr_reg);
					den = den * 64'(elapsed);
					raw = num / den;
					if (raw > 64'hFFFFFF)
						raw = 64'hFFFFFF;
				end
				a = (alpha_reg > 17'd65536) ? 64'd65536 : 64'(alpha_reg);
				acc = 64'(rpm_filt);
				acc = a * raw + (64'd65536 - a) * acc + 64'd32768;
				rpm_filt = acc[39:16];
				pulse_cnt = 16'd0;
				last_ms = now;
				// Faster rotation shortens the interval, down to 1 ms.
				whole = rpm_filt[23:8];
				if (whole < 16'd300) begin
					intv_ms = 9'd300;
				end else begin
					drop = (whole - 16'd300) / 16'd6;
					intv_ms = (drop >= 16'd299) ? 9'd1 : 9'd300 - drop[8:0];
				end
			end
		end
		r.rpm = rpm_filt;
		r.measured = meas;
		r.intv = intv_ms;
		r.magnet = armed;
		r.pulses = pulse_cnt;
		return r;
	endfunction

	// Offers one input transaction, sometimes after a random gap unless the
	// run is in its calm part. The expectation is queued at the accepting edge.
	task automatic send_item(input logic op, input logic [9:0] level, input logic [31:0] now,
			input logic typed, input tach_result_t want);
		tach_result_t pred;
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'd0, now, level};
		do @(posedge clk); while (!s_tready);
		pred = tach_step(op, level, now);
		result_q.push_back(typed ? want : pred);
		items_sent++;
	endtask

	task automatic send_plain(input logic op, input logic [9:0] level, input logic [31:0] now);
		send_item(op, level, now, 1'b0, '0);
	endtask

	// Register writes only happen with the block drained: the input stream is
	// lowered and every queued result must have come back first.
	task automatic write_reg(input logic [7:0] idx, input logic [16:0] val);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (result_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_HIGH_THR: hi_thr = val[9:0];
			CFG_LOW_THR:  lo_thr = val[9:0];
			CFG_PPR:      ppr_reg = val[7:0];
			CFG_ALPHA:    alpha_reg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_item(input logic op, input logic [9:0] level, input logic [31:0] now,
			input logic typed, input tach_result_t want);
		dir_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.op = op;
		row.level = level;
		row.now = now;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	task automatic add_cfg(input logic [7:0] idx, input logic [16:0] val);
		dir_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.idx = idx;
		row.val = val;
		dir_rows.push_back(row);
	endtask

	// A level in [lo_v, hi_v]; when that range is empty or leaves 0..1023, any level will do.
	function automatic logic [9:0] pick_between(input int lo_v, input int hi_v);
		if (lo_v > hi_v || lo_v < 0 || hi_v > 1023)
			return 10'($urandom_range(1023, 0));
		return 10'($urandom_range(hi_v, lo_v));
	endfunction

	// Chooses a fresh setting of all four registers, leaning on the extremes.
	task automatic pick_config();
		int hv;
		int lv;
		case ($urandom_range(0, 3))
			0: hv = 1023;
			1: hv = 0;
			default: hv = $urandom_range(900, 300);
		endcase
		case ($urandom_range(0, 5))
			0: lv = 0;
			1: lv = 1023;
			default: lv = $urandom_range(hv, 0);
		endcase
		write_reg(CFG_HIGH_THR, 17'(hv));
		write_reg(CFG_LOW_THR, 17'(lv));
		case ($urandom_range(0, 4))
			0: write_reg(CFG_PPR, 17'd0);
			1: write_reg(CFG_PPR, 17'd1);
			2: write_reg(CFG_PPR, 17'd255);
			default: write_reg(CFG_PPR, 17'($urandom_range(8, 1)));
		endcase
		case ($urandom_range(0, 5))
			0: write_reg(CFG_ALPHA, 17'd0);
			1: write_reg(CFG_ALPHA, 17'd65536);
			2: write_reg(CFG_ALPHA, 17'h1FFFF);
			3: write_reg(CFG_ALPHA, 17'($urandom_range(17'h1FFFF, 0)));
			default: write_reg(CFG_ALPHA, 17'($urandom_range(65535, 1)));
		endcase
	endtask

	// One random phase. Most of the traffic is rotation: magnet passes at a
	// steady pulse period with update requests on a coherent millisecond clock.
	// The rest is updates on that clock, period changes and stray items.
	task automatic run_phase(input int n_items);
		int          target;
		int          roll;
		logic [31:0] t;
		target = items_sent + n_items;
		while (items_sent < target) begin
			roll = $urandom_range(99, 0);
			if (roll < 70) begin
				send_plain(OP_SAMPLE, pick_between(int'(hi_thr) + 1, 1023), $urandom);
				repeat ($urandom_range(2, 0))
					send_plain(OP_SAMPLE, pick_between(int'(lo_thr), int'(hi_thr)),
							$urandom);
				send_plain(OP_SAMPLE, pick_between(0, int'(lo_thr) - 1), $urandom);
				clock_ms = clock_ms + pulse_ms;
				if ($urandom_range(2, 0) == 0)
					send_plain(OP_UPDATE, 10'($urandom), clock_ms);
			end else if (roll < 80) begin
				clock_ms = clock_ms + $urandom_range(5, 0);
				send_plain(OP_UPDATE, 10'($urandom), clock_ms);
			end else if (roll < 85) begin
				pulse_ms = ($urandom_range(3, 0) == 0) ? $urandom_range(4, 1)
						: $urandom_range(300, 1);
			end else if (roll < 93) begin
				send_plain(OP_SAMPLE, 10'($urandom), $urandom);
			end else begin
				t = $urandom;
				send_plain(OP_UPDATE, 10'($urandom), t);
				if ($urandom_range(1, 0) == 1)
					clock_ms = t;
			end
		end
	endtask

	// Result checker: each accepted result against the oldest expectation.
	always @(posedge clk) begin : result_check
		tach_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (result_q.size() == 0) begin
				report_mismatch("unexpected result", 64'(m_tdata), 64'd0);
			end else begin
				want = result_q.pop_front();
				if (m_tdata[23:0] !== want.rpm)
					report_mismatch("rpm_value", 64'(m_tdata[23:0]), 64'(want.rpm));
				if (m_tuser !== want.measured)
					report_mismatch("measured", 64'(m_tuser), 64'(want.measured));
				if (m_tdata[32:24] !== want.intv)
					report_mismatch("interval_ms", 64'(m_tdata[32:24]), 64'(want.intv));
				if (m_tdata[33] !== want.magnet)
					report_mismatch("magnet_present", 64'(m_tdata[33]), 64'(want.magnet));
				if (m_tdata[49:34] !== want.pulses)
					report_mismatch("pulses", 64'(m_tdata[49:34]), 64'(want.pulses));
			end
		end
	end

	// Receiver. It stalls in random bursts, and once holds off for a long
	// stretch so that the block backs up and stalls its input. In the calm
	// part of the run it is always ready.
	initial begin : sink_ready
		int n;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 300) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_LEN) @(negedge clk);
			end else if (!calm && $urandom_range(4, 0) == 0) begin
				n = $urandom_range(10, 0);
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		tach_result_t w;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_SAMPLE;
		items_sent = 0;
		calm = 1'b0;
		clock_ms = 32'd0;
		pulse_ms = 50;

		// Predictor starts from the reset state.
		hi_thr = 10'd600;
		lo_thr = 10'd500;
		ppr_reg = 8'd1;
		alpha_reg = 17'd32768;
		armed = 1'b0;
		pulse_cnt = 16'd0;
		last_ms = 32'd0;
		rpm_filt = 24'd0;
		intv_ms = 9'd0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table. Threshold edges first: a level equal to a threshold
		// changes nothing, one step past it does.
		w = '{24'd0, 1'b0, 9'd0, 1'b0, 16'd0};
		add_item(OP_SAMPLE, 10'd0, 32'd0, 1'b1, w);
		w = '{24'd0, 1'b0, 9'd0, 1'b1, 16'd1};
		add_item(OP_SAMPLE, 10'd1023, 32'd0, 1'b1, w);
		add_item(OP_SAMPLE, 10'd600, 32'd0, 1'b1, w);
		add_item(OP_SAMPLE, 10'd500, 32'd0, 1'b1, w);
		w = '{24'd0, 1'b0, 9'd0, 1'b0, 16'd1};
		add_item(OP_SAMPLE, 10'd499, 32'd0, 1'b1, w);
		w = '{24'd0, 1'b0, 9'd0, 1'b1, 16'd2};
		add_item(OP_SAMPLE, 10'd601, 32'd0, 1'b1, w);
		// The first update measures at once. With no time elapsed and pulses
		// counted the raw rpm saturates, so half of full scale lands in the
		// filter and the interval drops to its floor.
		w = '{24'h800000, 1'b1, 9'd1, 1'b1, 16'd0};
		add_item(OP_UPDATE, 10'd0, 32'd0, 1'b1, w);
		w = '{24'h800000, 1'b0, 9'd1, 1'b1, 16'd0};
		add_item(OP_UPDATE, 10'd0, 32'd0, 1'b1, w);
		add_item(OP_UPDATE, 10'd0, 32'd1, 1'b0, '0);
		// Time running backwards wraps into a huge elapsed time, then wraps back.
		add_item(OP_UPDATE, 10'd0, 32'hFFFFFFFF, 1'b0, '0);
		add_item(OP_UPDATE, 10'd0, 32'd0, 1'b0, '0);
		// A zero pulses-per-rev value must act as one.
		add_cfg(CFG_PPR, 17'd0);
		add_item(OP_SAMPLE, 10'd0, 32'd0, 1'b0, '0);
		add_item(OP_SAMPLE, 10'd1023, 32'd0, 1'b0, '0);
		add_item(OP_UPDATE, 10'd0, 32'd1000, 1'b0, '0);
		// Alpha above one is clipped to one: the filter takes the raw value.
		add_cfg(CFG_ALPHA, 17'h1FFFF);
		add_item(OP_SAMPLE, 10'd0, 32'd0, 1'b0, '0);
		add_item(OP_SAMPLE, 10'd1023, 32'd0, 1'b0, '0);
		add_item(OP_UPDATE, 10'd0, 32'd2000, 1'b0, '0);
		// Alpha of zero freezes the filter.
		add_cfg(CFG_ALPHA, 17'd0);
		add_item(OP_UPDATE, 10'd0, 32'd3000, 1'b0, '0);
		// Thresholds at the top and bottom: the detector can never move.
		add_cfg(CFG_HIGH_THR, 17'd1023);
		add_cfg(CFG_LOW_THR, 17'd0);
		add_item(OP_SAMPLE, 10'd1023, 32'd0, 1'b0, '0);
		add_item(OP_SAMPLE, 10'd0, 32'd0, 1'b0, '0);
		// Thresholds swapped to the other extremes.
		add_cfg(CFG_HIGH_THR, 17'd0);
		add_cfg(CFG_LOW_THR, 17'd1023);
		add_item(OP_SAMPLE, 10'd0, 32'd0, 1'b0, '0);
		add_item(OP_SAMPLE, 10'd1, 32'd0, 1'b0, '0);
		add_cfg(CFG_PPR, 17'd255);
		add_item(OP_UPDATE, 10'd0, 32'd3001, 1'b0, '0);
		add_item(OP_UPDATE, 10'd0, 32'd3400, 1'b0, '0);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			else
				send_item(dir_rows[i].op, dir_rows[i].level, dir_rows[i].now,
						dir_rows[i].typed, dir_rows[i].want);
		end

		// Random phases, each under a new register setting. The register
		// writes drain the block, so the sender pauses between phases.
		clock_ms = 32'd4000;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			pick_config();
			run_phase(PHASE_ITEMS);
		end

		// Calm part: no idling on either side. A run of back-to-back magnet
		// passes, then a measurement of the count and one more update.
		calm = 1'b1;
		write_reg(CFG_HIGH_THR, 17'd0);
		write_reg(CFG_LOW_THR, 17'd1023);
		write_reg(CFG_PPR, 17'd1);
		write_reg(CFG_ALPHA, 17'd65536);
		send_plain(OP_SAMPLE, 10'd0, 32'd0);
		for (int k = 0; k < CALM_PASSES; k++) begin
			send_plain(OP_SAMPLE, 10'd1023, 32'd0);
			send_plain(OP_SAMPLE, 10'd0, 32'd0);
		end
		clock_ms = clock_ms + 32'd100000;
		send_plain(OP_UPDATE, 10'd0, clock_ms);
		send_plain(OP_SAMPLE, 10'd1023, 32'd0);
		send_plain(OP_UPDATE, 10'd0, clock_ms + 32'd300);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		// Leave room for any stray result the block might still produce.
		repeat (60) @(posedge clk);
		if (err_count == 0)
			$display("tb_hall_tachometer_ema_unit: clean");
		else
			$display("tb_hall_tachometer_ema_unit: errors");
		$finish;
	end

endmodule

### sim.f
design/hte_pkg.sv
design/hte_ctrl.sv
design/hte_dp.sv
design/hall_tachometer_ema_unit.sv
sim/tb_hall_tachometer_ema_unit.sv
